[hw/rtl/ptpfp_pkg.sv]
// Package for the PTP frame parser: constants, codes and the frame record type.
package ptpfp_pkg;

    localparam int HEADER_BYTES  = 34;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STORE_DEPTH   = 64;
    localparam int ITEM_COUNT    = 26;

    // Configuration register indexes
    localparam logic [2:0] CFG_PTP_TYPE  = 3'd0;
    localparam logic [2:0] CFG_VLAN_TYPE = 3'd1;
    localparam logic [2:0] CFG_QINQ_TYPE = 3'd2;
    localparam logic [2:0] CFG_VERSION   = 3'd3;
    localparam logic [2:0] CFG_PD_MAC    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_TAG_CUT   = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ST_VERSION   = 3'd4;
    localparam logic [2:0] ST_LENGTH    = 3'd5;
    localparam logic [2:0] ST_ANN_TIME  = 3'd6;

    // Item codes
    localparam logic [4:0] IT_TRANSPORT  = 5'd0;
    localparam logic [4:0] IT_MSG_TYPE   = 5'd1;
    localparam logic [4:0] IT_VERSION    = 5'd2;
    localparam logic [4:0] IT_MSG_LEN    = 5'd3;
    localparam logic [4:0] IT_DOMAIN     = 5'd4;
    localparam logic [4:0] IT_FLAGS      = 5'd5;
    localparam logic [4:0] IT_CORRECTION = 5'd6;
    localparam logic [4:0] IT_CLOCK_ID   = 5'd7;
    localparam logic [4:0] IT_PORT_NUM   = 5'd8;
    localparam logic [4:0] IT_SEQ_ID     = 5'd9;
    localparam logic [4:0] IT_CONTROL    = 5'd10;
    localparam logic [4:0] IT_LOG_INT    = 5'd11;
    localparam logic [4:0] IT_TS_SEC     = 5'd12;
    localparam logic [4:0] IT_TS_NSEC    = 5'd13;
    localparam logic [4:0] IT_OUTER_VID  = 5'd14;
    localparam logic [4:0] IT_INNER_VID  = 5'd15;
    localparam logic [4:0] IT_PD_FLAG    = 5'd16;
    localparam logic [4:0] IT_UTC_OFF    = 5'd17;
    localparam logic [4:0] IT_PRIO1      = 5'd18;
    localparam logic [4:0] IT_CLK_CLASS  = 5'd19;
    localparam logic [4:0] IT_CLK_ACC    = 5'd20;
    localparam logic [4:0] IT_VARIANCE   = 5'd21;
    localparam logic [4:0] IT_PRIO2      = 5'd22;
    localparam logic [4:0] IT_GM_ID      = 5'd23;
    localparam logic [4:0] IT_STEPS      = 5'd24;
    localparam logic [4:0] IT_TIME_SRC   = 5'd25;

    localparam logic [31:0] NANO_LIMIT = 32'd1_000_000_000;

    // One classified frame, handed from front to back
    typedef struct packed {
        logic [2:0]                    status;
        logic [ITEM_COUNT-1:0]         mask;
        logic [11:0]                   outer_vid;
        logic [11:0]                   inner_vid;
        logic                          pd_flag;
        logic [STORE_DEPTH-1:0][7:0]   msg;
    } rec_t;

endpackage

[hw/rtl/ptp_ethernet_frame_parser_top.sv]
// Top level of the PTP over Ethernet frame parser.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | push / full            | frame_byte, end_of_frame
//  result   | empty / pop            | status, item_code, item_value, last_item
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One frame byte is taken every cycle while full is low; full rises only when
// two classified frames are queued and the back end has not drained them.
// The back end emits one item per cycle from the head frame while the result is
// empty or popped, so a frame yields as many results as it has items (1 to 26).
// Reset clears all parse and queue state; the message store needs no clearing.
// A stalled result holds in the output register while input beats continue.
module ptp_ethernet_frame_parser_top #(
    parameter int COUNT_BITS = ptpfp_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  frame_byte,
    input  logic        end_of_frame,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [4:0]  item_code,
    output logic [63:0] item_value,
    output logic        last_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import ptpfp_pkg::*;

    rec_t front_rec, head_rec;
    logic rec_push, rec_pop, q_empty, accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    ptpfp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rec_push     (rec_push),
        .rec          (front_rec)
    );

    ptpfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (front_rec),
        .rd_en   (rec_pop),
        .rd_data (head_rec),
        .full    (full),
        .empty   (q_empty)
    );

    ptpfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (head_rec),
        .rec_empty  (q_empty),
        .rec_pop    (rec_pop),
        .pop        (pop),
        .empty      (empty),
        .status     (status),
        .item_code  (item_code),
        .item_value (item_value),
        .last_item  (last_item)
    );

endmodule

[hw/rtl/ptpfp_front.sv]
// Front end: byte parser, tag stripping, message capture and frame classification.
module ptpfp_front #(
    parameter int COUNT_BITS = ptpfp_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        frame_byte,
    input  logic              end_of_frame,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [47:0]       cfg_data,
    output logic              rec_push,
    output ptpfp_pkg::rec_t   rec
);
    import ptpfp_pkg::*;

    localparam int CW = COUNT_BITS + 1;

    logic [15:0]           ptp_type_reg, vlan_type_reg, qinq_type_reg;
    logic [3:0]            version_reg;
    logic [47:0]           pd_mac_reg;

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [15:0]           ts_reg, ts_next;
    logic [4:0]            ms_reg, ms_next;
    logic [12:0]           otag_reg, otag_next, itag_reg, itag_next;
    logic [47:0]           dmac_reg, dmac_next;
    logic [7:0]            msg_reg [STORE_DEPTH];

    logic [CW-1:0]         p_w, ms_w, f_w;
    logic [COUNT_BITS-1:0] off;
    logic                  in_hdr, store_en;
    logic [5:0]            addr;
    logic [STORE_DEPTH-1:0][7:0] msg_v;
    logic [15:0]           len;
    logic [31:0]           nanos;
    logic [2:0]            st, st_fin;
    logic [3:0]            mt;
    logic                  nanos_ok, ts_ok, ann;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptp_type_reg  <= 16'h88F7;
            vlan_type_reg <= 16'h8100;
            qinq_type_reg <= 16'h88A8;
            version_reg   <= 4'd2;
            pd_mac_reg    <= 48'h0180_C200_000E;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PTP_TYPE:  ptp_type_reg  <= cfg_data[15:0];
                CFG_VLAN_TYPE: vlan_type_reg <= cfg_data[15:0];
                CFG_QINQ_TYPE: qinq_type_reg <= cfg_data[15:0];
                CFG_VERSION:   version_reg   <= cfg_data[3:0];
                CFG_PD_MAC:    pd_mac_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Per-beat parse state update
    always_comb
    begin
        p_w      = {1'b0, cnt_reg};
        ms_w     = CW'(ms_reg);
        in_hdr   = p_w < ms_w;
        off      = cnt_reg - COUNT_BITS'(ms_reg);
        store_en = !in_hdr && (off[COUNT_BITS-1:6] == '0);
        addr     = off[5:0];

        dmac_next = dmac_reg;
        ts_next   = ts_reg;
        ms_next   = ms_reg;
        otag_next = otag_reg;
        itag_next = itag_reg;

        if (p_w < CW'(6))
            dmac_next = {dmac_reg[39:0], frame_byte};
        if (in_hdr)
        begin
            ts_next = {ts_reg[7:0], frame_byte};
            if (ms_reg > 5'd14 && p_w + CW'(3) == ms_w)
            begin
                if (itag_reg[12])
                    itag_next = {1'b1, ts_next[11:0]};
                else
                    otag_next = {1'b1, ts_next[11:0]};
            end
            if (p_w + CW'(1) == ms_w)
            begin
                if (ms_reg == 5'd14 && ts_next == qinq_type_reg)
                begin
                    otag_next = 13'h1000;
                    ms_next   = 5'd18;
                end
                else if (!itag_reg[12] && ts_next == vlan_type_reg)
                begin
                    itag_next = 13'h1000;
                    ms_next   = ms_reg + 5'd4;
                end
            end
        end
        cnt_next = (&cnt_reg) ? cnt_reg : cnt_reg + COUNT_BITS'(1);
    end

    // Message bytes including this beat
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            msg_v[i] = (store_en && addr == 6'(i)) ? frame_byte : msg_reg[i];
    end

    // End-of-frame classification
    always_comb
    begin
        f_w      = {1'b0, cnt_next};
        len      = {msg_v[2], msg_v[3]};
        nanos    = {msg_v[40], msg_v[41], msg_v[42], msg_v[43]};
        nanos_ok = nanos < NANO_LIMIT;
        mt       = msg_v[0][3:0];
        if (cnt_next < COUNT_BITS'(14))
            st = ST_SHORT;
        else if ((otag_next[12] || itag_next[12]) && f_w < CW'(ms_next))
            st = ST_TAG_CUT;
        else if (ts_next != ptp_type_reg)
            st = ST_BAD_TYPE;
        else if (f_w < CW'(ms_next) + CW'(HEADER_BYTES))
            st = ST_SHORT;
        else if (msg_v[1][3:0] != version_reg)
            st = ST_VERSION;
        else if (len < 16'(HEADER_BYTES) || 32'(f_w - CW'(ms_next)) < 32'(len))
            st = ST_LENGTH;
        else
            st = ST_OK;

        ts_ok  = 1'b0;
        ann    = 1'b0;
        st_fin = st;
        if (st == ST_OK)
        begin
            // body >= 10 and body >= 30 expressed on the length
            if ((mt == 4'h0 || mt == 4'h8) && len >= 16'd44 && nanos_ok)
                ts_ok = 1'b1;
            if (mt == 4'hB && len >= 16'd64)
            begin
                if (!nanos_ok)
                    st_fin = ST_ANN_TIME;
                else
                begin
                    ts_ok = 1'b1;
                    ann   = 1'b1;
                end
            end
        end

        rec.status    = st_fin;
        rec.outer_vid = otag_next[11:0];
        rec.inner_vid = itag_next[11:0];
        rec.pd_flag   = dmac_next == pd_mac_reg;
        rec.msg       = msg_v;
        if (st_fin != ST_OK)
            rec.mask = ITEM_COUNT'(1);
        else
            rec.mask = {{9{ann}}, 1'b1, itag_next[12], otag_next[12], ts_ok, ts_ok,
                        12'hFFF};
    end

    assign rec_push = accept && end_of_frame;

    // Parse state registers, cleared at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ts_reg   <= '0;
            ms_reg   <= 5'd14;
            otag_reg <= '0;
            itag_reg <= '0;
            dmac_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_frame)
            begin
                cnt_reg  <= '0;
                ts_reg   <= '0;
                ms_reg   <= 5'd14;
                otag_reg <= '0;
                itag_reg <= '0;
                dmac_reg <= '0;
            end
            else
            begin
                cnt_reg  <= cnt_next;
                ts_reg   <= ts_next;
                ms_reg   <= ms_next;
                otag_reg <= otag_next;
                itag_reg <= itag_next;
                dmac_reg <= dmac_next;
            end
        end
    end

    // Message byte store
    always_ff @(posedge clk)
    begin
        if (accept && store_en)
            msg_reg[addr] <= frame_byte;
    end

endmodule

[hw/rtl/ptpfp_queue.sv]
// Two-entry queue of classified frames between front and back.
module ptpfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  ptpfp_pkg::rec_t   wr_data,
    input  logic              rd_en,
    output ptpfp_pkg::rec_t   rd_data,
    output logic              full,
    output logic              empty
);
    import ptpfp_pkg::*;

    rec_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= !wp_reg;
            if (rd_en)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

[hw/rtl/ptpfp_back.sv]
// Back end: walks the item mask of the head frame and fills the result register.
module ptpfp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ptpfp_pkg::rec_t   rec,
    input  logic              rec_empty,
    output logic              rec_pop,
    input  logic              pop,
    output logic              empty,
    output logic [2:0]        status,
    output logic [4:0]        item_code,
    output logic [63:0]       item_value,
    output logic              last_item
);
    import ptpfp_pkg::*;

    logic [ITEM_COUNT-1:0] rem_reg, mask, rem_next;
    logic                  act_reg, ov_reg, emit;
    logic [4:0]            idx;
    logic [63:0]           val;
    logic [2:0]            status_reg;
    logic [4:0]            code_reg;
    logic [63:0]           value_reg;
    logic                  last_reg;
    logic [STORE_DEPTH-1:0][7:0] m;

    assign m    = rec.msg;
    assign mask = act_reg ? rem_reg : rec.mask;
    assign emit = !rec_empty && (!ov_reg || pop);

    // Lowest pending item
    always_comb
    begin
        idx = '0;
        for (int i = ITEM_COUNT - 1; i >= 0; i--)
            if (mask[i])
                idx = 5'(i);
        rem_next = mask & ~(ITEM_COUNT'(1) << idx);
    end

    assign rec_pop = emit && (rem_next == '0);

    // Item value selection
    always_comb
    begin
        case (idx)
            IT_TRANSPORT:  val = 64'(m[0][7:4]);
            IT_MSG_TYPE:   val = 64'(m[0][3:0]);
            IT_VERSION:    val = 64'(m[1][3:0]);
            IT_MSG_LEN:    val = 64'({m[2], m[3]});
            IT_DOMAIN:     val = 64'(m[4]);
            IT_FLAGS:      val = 64'({m[6], m[7]});
            IT_CORRECTION: val = {m[8], m[9], m[10], m[11], m[12], m[13], m[14], m[15]};
            IT_CLOCK_ID:   val = {m[20], m[21], m[22], m[23], m[24], m[25], m[26], m[27]};
            IT_PORT_NUM:   val = 64'({m[28], m[29]});
            IT_SEQ_ID:     val = 64'({m[30], m[31]});
            IT_CONTROL:    val = 64'(m[32]);
            IT_LOG_INT:    val = 64'(m[33]);
            IT_TS_SEC:     val = 64'({m[34], m[35], m[36], m[37], m[38], m[39]});
            IT_TS_NSEC:    val = 64'({m[40], m[41], m[42], m[43]});
            IT_OUTER_VID:  val = 64'(rec.outer_vid);
            IT_INNER_VID:  val = 64'(rec.inner_vid);
            IT_PD_FLAG:    val = 64'(rec.pd_flag);
            IT_UTC_OFF:    val = 64'({m[44], m[45]});
            IT_PRIO1:      val = 64'(m[47]);
            IT_CLK_CLASS:  val = 64'(m[48]);
            IT_CLK_ACC:    val = 64'(m[49]);
            IT_VARIANCE:   val = 64'({m[50], m[51]});
            IT_PRIO2:      val = 64'(m[52]);
            IT_GM_ID:      val = {m[53], m[54], m[55], m[56], m[57], m[58], m[59], m[60]};
            IT_STEPS:      val = 64'({m[61], m[62]});
            IT_TIME_SRC:   val = 64'(m[63]);
            default:       val = '0;
        endcase
        if (rec.status != ST_OK)
            val = '0;
    end

    // Walk control and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            rem_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                act_reg <= rem_next != '0;
                rem_reg <= rem_next;
                ov_reg  <= 1'b1;
            end
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= rec.status;
            code_reg   <= idx;
            value_reg  <= val;
            last_reg   <= rem_next == '0;
        end
    end

    assign empty      = !ov_reg;
    assign status     = status_reg;
    assign item_code  = code_reg;
    assign item_value = value_reg;
    assign last_item  = last_reg;

endmodule

[hw/rtl/ptpfp_checker.sv]
// Port-level checks for the PTP frame parser and their binding.
module ptpfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic [4:0]  item_code,
    input logic [63:0] item_value,
    input logic        last_item
);
    import ptpfp_pkg::*;

    // An error result stands alone with zero code and value
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (last_item && item_code == IT_TRANSPORT
                                         && item_value == '0))
        else $error("error result not a lone zero item");

    // Status stays within its code range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= ST_ANN_TIME))
        else $error("status out of range");

    // Item codes stay within the decoded set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (item_code <= IT_TIME_SRC))
        else $error("item code out of range");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(item_code) && $stable(item_value)))
        else $error("result changed while stalled");

endmodule

bind ptp_ethernet_frame_parser_top ptpfp_checker u_chk (.*);

[test/tb_ptp_ethernet_frame_parser_top.sv]
// Testbench for the PTP over Ethernet frame parser: directed and random frames checked per item.
module tb_ptp_ethernet_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptpfp_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [4:0]  code;
        logic [63:0] value;
        logic        last;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  frame_byte;
    logic        end_of_frame;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [4:0]  item_code;
    logic [63:0] item_value;
    logic        last_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    ptp_ethernet_frame_parser_top i_dut (.*);

    // parser copy of the block state and registers
    logic [15:0] ptp_type_reg, vlan_type_reg, qinq_type_reg;
    logic [3:0]  version_reg;
    logic [47:0] pd_mac_reg;
    logic [15:0] seen_bytes;
    logic [15:0] last_two;
    int          msg_offset;
    logic [12:0] outer_tag, inner_tag;
    logic [47:0] dest_mac;
    logic [7:0]  msg_bytes [64];

    item_t expected_items[$];
    int    errors;
    bit    hold_off;     // long receiver stall request
    int    stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_ptp_ethernet_frame_parser_top NOT OK");
        $finish;
    end

    function automatic logic [15:0] rd16(int off);
        return {msg_bytes[off & 63], msg_bytes[(off + 1) & 63]};
    endfunction

    function automatic logic [31:0] rd32(int off);
        return {rd16(off), rd16(off + 2)};
    endfunction

    function automatic logic [63:0] rd64(int off);
        return {rd32(off), rd32(off + 4)};
    endfunction

    function automatic void add_item(logic [2:0] st, logic [4:0] code, logic [63:0] val);
        item_t it;
        it.status = st;
        it.code   = code;
        it.value  = val;
        it.last   = 1'b0;
        expected_items.push_back(it);
    endfunction

    function automatic void reset_frame();
        seen_bytes = '0;
        last_two   = '0;
        msg_offset = 14;
        outer_tag  = '0;
        inner_tag  = '0;
        dest_mac   = '0;
    endfunction

    // build the items of a finished frame
    function automatic void decode_frame();
        int         f, len, body;
        logic [2:0] st;
        logic [3:0] mt;
        bit         ts_ok, ann, nanos_ok;
        item_t      tail;
        f   = int'(seen_bytes);
        st  = ST_OK;
        len = 0;
        ts_ok = 0;
        ann   = 0;
        if (f < 14) st = ST_SHORT;
        else if ((outer_tag[12] || inner_tag[12]) && f < msg_offset) st = ST_TAG_CUT;
        else if (last_two != ptp_type_reg) st = ST_BAD_TYPE;
        else if (f < msg_offset + HEADER_BYTES) st = ST_SHORT;
        else if (msg_bytes[1][3:0] != version_reg) st = ST_VERSION;
        else
        begin
            len = int'(rd16(2));
            if (len < HEADER_BYTES || f - msg_offset < len) st = ST_LENGTH;
        end
        if (st == ST_OK)
        begin
            mt = msg_bytes[0][3:0];
            body = len - HEADER_BYTES;
            nanos_ok = rd32(HEADER_BYTES + 6) < NANO_LIMIT;
            if ((mt == 4'h0 || mt == 4'h8) && body >= 10 && nanos_ok) ts_ok = 1;
            if (mt == 4'hB && body >= 30)
            begin
                if (!nanos_ok) st = ST_ANN_TIME;
                else
                begin
                    ts_ok = 1;
                    ann = 1;
                end
            end
        end
        if (st != ST_OK)
            add_item(st, IT_TRANSPORT, '0);
        else
        begin
            add_item(ST_OK, IT_TRANSPORT, 64'(msg_bytes[0][7:4]));
            add_item(ST_OK, IT_MSG_TYPE, 64'(msg_bytes[0][3:0]));
            add_item(ST_OK, IT_VERSION, 64'(msg_bytes[1][3:0]));
            add_item(ST_OK, IT_MSG_LEN, 64'(len));
            add_item(ST_OK, IT_DOMAIN, 64'(msg_bytes[4]));
            add_item(ST_OK, IT_FLAGS, 64'(rd16(6)));
            add_item(ST_OK, IT_CORRECTION, rd64(8));
            add_item(ST_OK, IT_CLOCK_ID, rd64(20));
            add_item(ST_OK, IT_PORT_NUM, 64'(rd16(28)));
            add_item(ST_OK, IT_SEQ_ID, 64'(rd16(30)));
            add_item(ST_OK, IT_CONTROL, 64'(msg_bytes[32]));
            add_item(ST_OK, IT_LOG_INT, 64'(msg_bytes[33]));
            if (ts_ok)
            begin
                add_item(ST_OK, IT_TS_SEC,
                         64'({rd16(HEADER_BYTES), rd32(HEADER_BYTES + 2)}));
                add_item(ST_OK, IT_TS_NSEC, 64'(rd32(HEADER_BYTES + 6)));
            end
            if (outer_tag[12]) add_item(ST_OK, IT_OUTER_VID, 64'(outer_tag[11:0]));
            if (inner_tag[12]) add_item(ST_OK, IT_INNER_VID, 64'(inner_tag[11:0]));
            add_item(ST_OK, IT_PD_FLAG, 64'(dest_mac == pd_mac_reg));
            if (ann)
            begin
                add_item(ST_OK, IT_UTC_OFF, 64'(rd16(HEADER_BYTES + 10)));
                add_item(ST_OK, IT_PRIO1, 64'(msg_bytes[HEADER_BYTES + 13]));
                add_item(ST_OK, IT_CLK_CLASS, 64'(msg_bytes[HEADER_BYTES + 14]));
                add_item(ST_OK, IT_CLK_ACC, 64'(msg_bytes[HEADER_BYTES + 15]));
                add_item(ST_OK, IT_VARIANCE, 64'(rd16(HEADER_BYTES + 16)));
                add_item(ST_OK, IT_PRIO2, 64'(msg_bytes[HEADER_BYTES + 18]));
                add_item(ST_OK, IT_GM_ID, rd64(HEADER_BYTES + 19));
                add_item(ST_OK, IT_STEPS, 64'(rd16(HEADER_BYTES + 27)));
                add_item(ST_OK, IT_TIME_SRC, 64'(msg_bytes[HEADER_BYTES + 29]));
            end
        end
        tail = expected_items.pop_back();
        tail.last = 1'b1;
        expected_items.push_back(tail);
    endfunction

    // advance the predictor by one accepted byte
    function automatic void predict_byte(logic [7:0] b, logic eof);
        int p;
        p = int'(seen_bytes);
        if (p < 6) dest_mac = {dest_mac[39:0], b};
        if (p < msg_offset)
        begin
            last_two = {last_two[7:0], b};
            if (msg_offset > 14 && p + 3 == msg_offset)
            begin
                if (inner_tag[12]) inner_tag = {1'b1, last_two[11:0]};
                else outer_tag = {1'b1, last_two[11:0]};
            end
            if (p + 1 == msg_offset)
            begin
                if (msg_offset == 14 && last_two == qinq_type_reg)
                begin
                    outer_tag = 13'h1000;
                    msg_offset = 18;
                end
                else if (!inner_tag[12] && last_two == vlan_type_reg)
                begin
                    inner_tag = 13'h1000;
                    msg_offset += 4;
                end
            end
        end
        else if (p - msg_offset < 64)
            msg_bytes[p - msg_offset] = b;
        if (seen_bytes != 16'hFFFF) seen_bytes++;
        if (eof)
        begin
            decode_frame();
            reset_frame();
        end
    endfunction

    // receiver: random stall pattern plus long hold-off; checks every beat
    always @(negedge clk)
    begin
        if (!rst_n || hold_off) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_items.size() == 0)
            begin
                $display("%t: unexpected item code %0d value %h", $realtime, item_code,
                         item_value);
                errors++;
            end
            else
            begin
                want = expected_items.pop_front();
                if (status !== want.status || item_code !== want.code ||
                    item_value !== want.value || last_item !== want.last)
                begin
                    $display("%t: mismatch expected st %0d code %0d val %h last %b",
                             $realtime, want.status, want.code, want.value, want.last);
                    $display("%t:          actual   st %0d code %0d val %h last %b",
                             $realtime, status, item_code, item_value, last_item);
                    errors++;
                end
            end
        end
    end

    // send one byte, waiting until it is accepted
    task automatic send_byte(logic [7:0] b, logic eof);
        push         = 1'b1;
        frame_byte   = b;
        end_of_frame = eof;
        do @(posedge clk); while (full);
        predict_byte(b, eof);
        @(negedge clk);
        push = 1'b0;
    endtask

    // send a frame with bursty gaps
    task automatic send_frame(logic [7:0] bytes[$]);
        foreach (bytes[i])
        begin
            if ($urandom_range(9) == 0) repeat ($urandom_range(6)) @(negedge clk);
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic drain();
        while (expected_items.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PTP_TYPE:  ptp_type_reg  = val[15:0];
            CFG_VLAN_TYPE: vlan_type_reg = val[15:0];
            CFG_QINQ_TYPE: qinq_type_reg = val[15:0];
            CFG_VERSION:   version_reg   = val[3:0];
            CFG_PD_MAC:    pd_mac_reg    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // build a frame: kind 0 sync,1 follow-up,2 announce,3 other type
    task automatic build_frame(output logic [7:0] q[$], input int tags, input int kind,
                               input bit good_ns, input bit pd, input int extra);
        int          len, body;
        logic [31:0] ns;
        logic [47:0] mac;
        q = {};
        mac = pd ? pd_mac_reg : 48'({$urandom, $urandom});
        for (int i = 5; i >= 0; i--) q.push_back(mac[i*8 +: 8]);
        repeat (6) q.push_back(8'($urandom));
        if (tags >= 2)
        begin
            q.push_back(qinq_type_reg[15:8]);
            q.push_back(qinq_type_reg[7:0]);
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
        end
        if (tags >= 1)
        begin
            q.push_back(vlan_type_reg[15:8]);
            q.push_back(vlan_type_reg[7:0]);
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
        end
        q.push_back(ptp_type_reg[15:8]);
        q.push_back(ptp_type_reg[7:0]);
        body = (kind == 2) ? 30 : (kind == 3 ? int'($urandom_range(20)) : 10);
        if ($urandom_range(7) == 0) body = int'($urandom_range(29));
        len = HEADER_BYTES + body;
        q.push_back({4'($urandom_range(15)), kind == 0 ? 4'h0 : kind == 1 ? 4'h8 :
                     kind == 2 ? 4'hB : 4'($urandom_range(15))});
        q.push_back({4'($urandom), version_reg});
        q.push_back(len[15:8]);
        q.push_back(len[7:0]);
        for (int i = 4; i < len; i++) q.push_back(8'($urandom));
        ns = good_ns ? $urandom_range(999_999_999) : $urandom_range(32'hFFFF_FFFF, 1_000_000_000);
        for (int i = 0; i < 4; i++)
            if (body >= 10) q[q.size() - len + HEADER_BYTES + 6 + i] = ns[31 - 8*i -: 8];
        repeat (extra) q.push_back(8'($urandom));
    endtask

    task automatic test_directed();
        logic [7:0] q[$];
        build_frame(q, 2, 2, 1, 1, 0); send_frame(q);      // announce with both tags
        q = {8'hFF}; send_frame(q);                         // one-byte frame
        build_frame(q, 0, 0, 1, 0, 0); q = q[0:12]; send_frame(q);
        build_frame(q, 1, 0, 1, 0, 0); q = q[0:14]; send_frame(q);  // tag cut
        build_frame(q, 0, 0, 1, 0, 0); q = q[0:13]; q[12] = ~q[12]; send_frame(q);
        build_frame(q, 0, 0, 1, 0, 0); q = q[0:30]; send_frame(q);  // header cut
        drain();
    endtask

    task automatic test_random(int frames);
        logic [7:0] q[$];
        int         sel;
        for (int n = 0; n < frames; n++)
        begin
            sel = int'($urandom_range(9));
            build_frame(q, int'($urandom_range(2)), int'($urandom_range(3)),
                        $urandom_range(4) != 0, $urandom_range(1) == 1,
                        $urandom_range(2) == 0 ? int'($urandom_range(8)) : 0);
            if (sel == 0) q = q[0:$urandom_range(q.size() - 1)];
            if (sel == 1) q[$urandom_range(q.size() - 1)] = 8'($urandom);
            send_frame(q);
            if ($urandom_range(5) == 0) repeat ($urandom_range(30)) @(negedge clk);
        end
    endtask

    task automatic test_backpressure();
        logic [7:0] q[$];
        hold_off = 1'b1;
        fork
            begin
                for (int c = 0; c < 150; c++) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 4; n++)
            begin
                build_frame(q, 0, 0, 1, 0, 0);
                q = q[0:13];
                send_frame(q);
            end
        join
        drain();
    endtask

    task automatic test_config();
        write_reg(CFG_PTP_TYPE, 48'hFFFF);
        write_reg(CFG_VLAN_TYPE, 48'h0000);
        write_reg(CFG_QINQ_TYPE, 48'h1234);
        write_reg(CFG_VERSION, 48'hF);
        write_reg(CFG_PD_MAC, 48'hFFFF_FFFF_FFFF);
        test_random(1);
        drain();
        write_reg(CFG_PTP_TYPE, 48'h88F7);
        write_reg(CFG_VLAN_TYPE, 48'h8100);
        write_reg(CFG_QINQ_TYPE, 48'h88A8);
        write_reg(CFG_VERSION, 48'h2);
        write_reg(CFG_PD_MAC, 48'h0180_C200_000E);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        frame_byte = '0;
        end_of_frame = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        hold_off = 1'b0;
        stall_pct = 20;
        ptp_type_reg = 16'h88F7;
        vlan_type_reg = 16'h8100;
        qinq_type_reg = 16'h88A8;
        version_reg = 4'h2;
        pd_mac_reg = 48'h0180_C200_000E;
        foreach (msg_bytes[i]) msg_bytes[i] = '0;
        reset_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_config();
        drain();

        if (errors == 0)
            $display("tb_ptp_ethernet_frame_parser_top OK");
        else
            $display("tb_ptp_ethernet_frame_parser_top NOT OK");
        $finish;
    end

endmodule

[ptp_ethernet_frame_parser_top.f]
hw/rtl/ptpfp_pkg.sv
hw/rtl/ptpfp_front.sv
hw/rtl/ptpfp_queue.sv
hw/rtl/ptpfp_back.sv
hw/rtl/ptp_ethernet_frame_parser_top.sv
hw/rtl/ptpfp_checker.sv
test/tb_ptp_ethernet_frame_parser_top.sv
